[src/vsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vigenere stream cipher package
// Request and result payload types, request kinds and configuration register
// indices shared by the cipher modules.
// ----------------------------------------------------------------------------
package vsc_pkg;

    // Fixed widths of the request, result and configuration fields.
    localparam int CODE_W     = 16;
    localparam int SLOT_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Register values after reset.
    localparam logic [CFG_DATA_W-1:0] ALPHABET_SIZE_RST = 7'd26;
    localparam logic [CFG_DATA_W-1:0] KEY_LENGTH_RST    = 7'd1;

    // Kind of request carried on the input channel.
    typedef enum logic [1:0] {
        REQ_PROCESS  = 2'd0,
        REQ_ALPHA_WR = 2'd1,
        REQ_KEY_WR   = 2'd2,
        REQ_START    = 2'd3
    } req_kind_t;

    // Configuration register indices.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHABET_SIZE = 2'd0,
        CFG_KEY_LENGTH    = 2'd1,
        CFG_DECRYPT_MODE  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        req_kind_t           req_type;
        logic [CODE_W-1:0]   char_code;
        logic                is_letter;
        logic [SLOT_W-1:0]   entry_index;
    } vsc_req_t;

    typedef struct packed {
        logic [CODE_W-1:0]   out_char;
        logic                error;
    } vsc_res_t;

endpackage

[src/vsc_alpha.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alphabet store
// Holds the alphabet as a row of compare cells for two parallel lookups, and
// a memory copy of the same entries for reading the ciphered character.
// ----------------------------------------------------------------------------
module vsc_alpha #(
    parameter int ALPHABET_MAX = 64,
    parameter int CHAR_BITS    = 16,
    localparam int AW          = $clog2(ALPHABET_MAX),
    localparam int NW          = $clog2(ALPHABET_MAX + 1)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [CHAR_BITS-1:0] wr_data,
    input  logic [NW-1:0]        size,
    input  logic [CHAR_BITS-1:0] char_a,
    input  logic [CHAR_BITS-1:0] char_b,
    output logic                 hit_a,
    output logic [AW-1:0]        idx_a,
    output logic                 hit_b,
    output logic [AW-1:0]        idx_b,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [CHAR_BITS-1:0] rd_data
);

    import vsc_pkg::*;

    logic [CHAR_BITS-1:0] cell_reg [ALPHABET_MAX];
    logic [CHAR_BITS-1:0] copy_mem [ALPHABET_MAX];
    logic [CHAR_BITS-1:0] rd_data_reg;
    logic [ALPHABET_MAX-1:0] eq_a;
    logic [ALPHABET_MAX-1:0] eq_b;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            copy_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= copy_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

    // Only the first size entries take part in a lookup.
    always_comb
    begin
        for (int i = 0; i < ALPHABET_MAX; i++)
        begin
            eq_a[i] = (i < int'(size)) && (cell_reg[i] == char_a);
            eq_b[i] = (i < int'(size)) && (cell_reg[i] == char_b);
        end
    end

    // The lowest matching entry wins.
    always_comb
    begin
        idx_a = '0;
        idx_b = '0;
        for (int i = ALPHABET_MAX - 1; i >= 0; i--)
        begin
            if (eq_a[i])
            begin
                idx_a = AW'(i);
            end
            if (eq_b[i])
            begin
                idx_b = AW'(i);
            end
        end
    end

    assign hit_a = |eq_a;
    assign hit_b = |eq_b;

endmodule

[src/vsc_key_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key memory
// Key characters, written one slot at a time and read every cycle at the key
// position of the next cycle, with a bypass of a write to the same slot.
// ----------------------------------------------------------------------------
module vsc_key_mem #(
    parameter int KEY_MAX   = 64,
    parameter int CHAR_BITS = 16,
    localparam int PW       = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [PW-1:0]        wr_addr,
    input  logic [CHAR_BITS-1:0] wr_data,
    input  logic [PW-1:0]        rd_addr,
    output logic [CHAR_BITS-1:0] rd_data
);

    import vsc_pkg::*;

    logic [CHAR_BITS-1:0] key_mem [KEY_MAX];
    logic [CHAR_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/vsc_shift_idx.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shifted alphabet index
// Adds or subtracts the key index modulo the alphabet size with one
// conditional correction.
// ----------------------------------------------------------------------------
module vsc_shift_idx #(
    parameter int ALPHABET_MAX = 64,
    localparam int AW          = $clog2(ALPHABET_MAX),
    localparam int NW          = $clog2(ALPHABET_MAX + 1)
) (
    input  logic [AW-1:0] p_idx,
    input  logic [AW-1:0] k_idx,
    input  logic [NW-1:0] size,
    input  logic          decrypt,
    output logic [AW-1:0] r_idx
);

    import vsc_pkg::*;

    logic [AW:0] p_w;
    logic [AW:0] k_w;
    logic [AW:0] n_w;
    logic [AW:0] sum;
    logic [AW:0] res;

    assign p_w = (AW + 1)'(p_idx);
    assign k_w = (AW + 1)'(k_idx);
    assign n_w = (AW + 1)'(size);
    assign sum = p_w + k_w;

    always_comb
    begin
        if (decrypt)
        begin
            res = (p_w >= k_w) ? (p_w - k_w) : (p_w + n_w - k_w);
        end
        else
        begin
            res = (sum >= n_w) ? (sum - n_w) : sum;
        end
    end

    assign r_idx = AW'(res);

endmodule

[src/vigenere_stream_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vigenere stream cipher
// Ciphers a character stream over a loadable alphabet with a loadable key.
// Requests load the alphabet and key tables, start a message or carry one
// character; each character request gives one result.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload             | Direction
//  --------+----------------------+---------------------+----------
//  in      | in_valid / in_stall  | in_data  (vsc_req_t)| into block
//  out     | out_valid / out_stall| out_data (vsc_res_t)| out of block
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data | into block
//
// A request is taken into the input register, and the result of a character
// request is loaded into the output register as it leaves the stage; one
// request is taken every cycle while the input is not stalled.
// The step through the stage is set by the alphabet compare row, the index
// arithmetic and the read address of the key memory for the following
// request. rst_n clears the control state at once; the tables are undefined
// until written. The input stalls only while a character request waits in
// the stage and the output register holds a result that is being stalled.
// ----------------------------------------------------------------------------
module vigenere_stream_cipher #(
    parameter int ALPHABET_MAX = 64,
    parameter int KEY_MAX      = 64,
    parameter int CHAR_BITS    = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  vsc_pkg::vsc_req_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output vsc_pkg::vsc_res_t                    out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vsc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import vsc_pkg::*;

    localparam int AW = $clog2(ALPHABET_MAX);
    localparam int NW = $clog2(ALPHABET_MAX + 1);
    localparam int PW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LW = $clog2(KEY_MAX + 1);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] alphabet_size_reg;
    logic [CFG_DATA_W-1:0] key_length_reg;
    logic                  decrypt_mode_reg;

    // Input stage.
    logic     s_vld_reg;
    logic     s_vld_next;
    vsc_req_t s_req_reg;

    // Message state.
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] pos_wrap;
    logic [PW:0]   pos_inc;
    logic          err_reg;
    logic          err_next;

    // Output register.
    logic              out_vld_reg;
    logic              out_vld_next;
    logic              out_pass_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_err_reg;

    // Datapath.
    logic [NW-1:0]        eff_size;
    logic [LW-1:0]        eff_key;
    logic [CHAR_BITS-1:0] code_c;
    logic [CHAR_BITS-1:0] key_char;
    logic [CHAR_BITS-1:0] alpha_rd;
    logic                 hit_p;
    logic                 hit_k;
    logic [AW-1:0]        p_idx;
    logic [AW-1:0]        k_idx;
    logic [AW-1:0]        r_idx;

    // Control.
    logic is_proc;
    logic do_cipher;
    logic cipher_ok;
    logic out_free;
    logic fire;
    logic proc_fire;
    logic start_fire;
    logic advance;
    logic err_set;
    logic alpha_we;
    logic key_we;

    // ------------------------------------------------------------------
    // Configuration port. Writes are always taken; an unused index is
    // simply dropped.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_size_reg <= ALPHABET_SIZE_RST;
            key_length_reg    <= KEY_LENGTH_RST;
            decrypt_mode_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ALPHABET_SIZE: alphabet_size_reg <= cfg_data;
                CFG_KEY_LENGTH:    key_length_reg    <= cfg_data;
                CFG_DECRYPT_MODE:  decrypt_mode_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // The alphabet size saturates at the table depth. A key length of zero
    // counts as one, and a longer one saturates at the key table depth.
    assign eff_size = (int'(alphabet_size_reg) > ALPHABET_MAX) ?
                      NW'(ALPHABET_MAX) : NW'(alphabet_size_reg);

    always_comb
    begin
        if (key_length_reg == '0)
        begin
            eff_key = LW'(1);
        end
        else if (int'(key_length_reg) > KEY_MAX)
        begin
            eff_key = LW'(KEY_MAX);
        end
        else
        begin
            eff_key = LW'(key_length_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage control. Table writes and start requests give no result and
    // always leave the stage; a character request leaves it once the
    // output register is free or being emptied in the same cycle.
    // ------------------------------------------------------------------
    assign is_proc    = (s_req_reg.req_type == REQ_PROCESS);
    assign out_free   = !out_vld_reg || !out_stall;
    assign fire       = s_vld_reg && (!is_proc || out_free);
    assign proc_fire  = fire && is_proc;
    assign start_fire = fire && (s_req_reg.req_type == REQ_START);
    assign in_stall   = s_vld_reg && !fire;

    always_comb
    begin
        if (in_valid && !in_stall)
        begin
            s_vld_next = 1'b1;
        end
        else if (fire)
        begin
            s_vld_next = 1'b0;
        end
        else
        begin
            s_vld_next = s_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg <= 1'b0;
        end
        else
        begin
            s_vld_reg <= s_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s_req_reg <= in_data;
        end
    end

    // ------------------------------------------------------------------
    // Lookup and cipher arithmetic. Characters are compared within
    // CHAR_BITS bits.
    // ------------------------------------------------------------------
    assign code_c = CHAR_BITS'(s_req_reg.char_code);

    assign alpha_we = fire && (s_req_reg.req_type == REQ_ALPHA_WR) &&
                      (int'(s_req_reg.entry_index) < ALPHABET_MAX);
    assign key_we   = fire && (s_req_reg.req_type == REQ_KEY_WR) &&
                      (int'(s_req_reg.entry_index) < KEY_MAX);

    vsc_alpha #(
        .ALPHABET_MAX (ALPHABET_MAX),
        .CHAR_BITS    (CHAR_BITS)
    ) u_alpha (
        .clk     (clk),
        .wr_en   (alpha_we),
        .wr_addr (AW'(s_req_reg.entry_index)),
        .wr_data (code_c),
        .size    (eff_size),
        .char_a  (code_c),
        .char_b  (key_char),
        .hit_a   (hit_p),
        .idx_a   (p_idx),
        .hit_b   (hit_k),
        .idx_b   (k_idx),
        .rd_en   (proc_fire),
        .rd_addr (r_idx),
        .rd_data (alpha_rd)
    );

    vsc_shift_idx #(
        .ALPHABET_MAX (ALPHABET_MAX)
    ) u_shift (
        .p_idx   (p_idx),
        .k_idx   (k_idx),
        .size    (eff_size),
        .decrypt (decrypt_mode_reg),
        .r_idx   (r_idx)
    );

    // The key memory is read at the position the next request will use,
    // so the key character is always waiting in its read register.
    vsc_key_mem #(
        .KEY_MAX   (KEY_MAX),
        .CHAR_BITS (CHAR_BITS)
    ) u_key (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (PW'(s_req_reg.entry_index)),
        .wr_data (code_c),
        .rd_addr (pos_next),
        .rd_data (key_char)
    );

    // ------------------------------------------------------------------
    // Key position and error latch. A failed lookup leaves the position
    // where it is and sets the latch until the next start request. A
    // position left beyond a shortened key wraps to zero after use.
    // ------------------------------------------------------------------
    assign do_cipher = is_proc && s_req_reg.is_letter;
    assign cipher_ok = hit_p && hit_k;
    assign advance   = fire && do_cipher && cipher_ok;
    assign err_set   = fire && do_cipher && !cipher_ok;

    assign pos_inc  = (PW + 1)'(pos_reg) + (PW + 1)'(1);
    assign pos_wrap = (int'(pos_inc) >= int'(eff_key)) ? '0 : PW'(pos_inc);

    always_comb
    begin
        if (start_fire)
        begin
            pos_next = '0;
            err_next = 1'b0;
        end
        else
        begin
            pos_next = advance ? pos_wrap : pos_reg;
            err_next = err_reg || err_set;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            err_reg <= err_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register. The ciphered character comes from the registered
    // read of the alphabet memory; anything else passes through.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (proc_fire)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            out_pass_reg <= !(do_cipher && cipher_ok);
            out_code_reg <= CODE_W'(code_c);
            out_err_reg  <= err_next;
        end
    end

    assign out_valid         = out_vld_reg;
    assign out_data.out_char = out_pass_reg ? out_code_reg : CODE_W'(alpha_rd);
    assign out_data.error    = out_err_reg;

`ifndef SYNTHESIS
    // The input is only ever held up by a stalled result.
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    // A start request rewinds the key and clears the error.
    a_start_clears : assert property (@(posedge clk) disable iff (!rst_n)
        start_fire |=> ((pos_reg == '0) && !err_reg))
        else $error("start request did not rewind the message state");

    // The error latch only drops on a start request.
    a_err_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(err_reg) |-> $past(start_fire))
        else $error("error latch cleared without a start request");

    // Every character request that leaves the stage gives a result.
    a_result_loaded : assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire |=> out_valid)
        else $error("character request left the stage without a result");
`endif

endmodule
